/* rtl/urde_pkg.sv */
package urde_pkg;

   // Fixed field widths of the two channels.
   localparam int VALUE_BITS = 64;
   localparam int DIGIT_BITS = 4;
   localparam int RADIX_BITS = DIGIT_BITS + 1;
   localparam int CHAR_BITS  = 7;

   // Radix limits after clamping.
   localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);

   // Character codes used by the digit encoder.
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = CHAR_BITS'(48);
   localparam logic [CHAR_BITS-1:0] CHAR_UPPER = CHAR_BITS'(65);
   localparam logic [CHAR_BITS-1:0] CHAR_LOWER = CHAR_BITS'(97);
   localparam logic [DIGIT_BITS-1:0] DIGIT_TEN = DIGIT_BITS'(10);

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0] radix;
      logic                  uppercase;
   } req_data_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] char_code;
      logic                 last_digit;
   } rsp_data_type;

   // Control that the sequencer broadcasts to every digit cell.
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // ASCII code of one digit.
   function automatic logic [CHAR_BITS-1:0] char_of(input logic [DIGIT_BITS-1:0] digit,
                                                   input logic upper);
      logic [CHAR_BITS-1:0] code;
      if (digit < DIGIT_TEN) begin
         code = CHAR_ZERO + CHAR_BITS'(digit);
      end else begin
         code = (upper ? CHAR_UPPER : CHAR_LOWER) + CHAR_BITS'(digit - DIGIT_TEN);
      end
      return code;
   endfunction

endpackage

/* rtl/urde_cell.sv */
module urde_cell
   import urde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [RADIX_BITS-1:0] radix,
   input  logic                  act_prev,
   input  logic                  carry_prev,
   input  logic [DIGIT_BITS-1:0] digit_prev,
   output logic                  act_out,
   output logic                  carry_out,
   output logic [DIGIT_BITS-1:0] digit_out
);

   logic [DIGIT_BITS-1:0] digit_ff, digit_in;
   logic                  act_ff, act_in;
   logic                  carry_ff, carry_in;
   logic [RADIX_BITS-1:0] dbl;
   logic [RADIX_BITS-1:0] diff;
   logic                  over;

   // Doubling step: twice the digit plus the carry from the cell below.
   assign dbl  = {digit_ff, carry_prev};
   assign over = dbl >= radix;
   assign diff = dbl - radix;

   // Next digit, carry and activity token.
   always_comb begin
      act_in   = ~ctl.clear & act_prev;
      carry_in = ~ctl.clear & act_prev & over;
      priority if (ctl.clear) begin
         digit_in = '0;
      end else if (act_prev) begin
         digit_in = over ? diff[DIGIT_BITS-1:0] : dbl[DIGIT_BITS-1:0];
      end else if (ctl.shift) begin
         digit_in = digit_prev;
      end else begin
         digit_in = digit_ff;
      end
   end

   // Activity and carry are control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= 1'b0;
         carry_ff <= 1'b0;
      end else begin
         act_ff   <= act_in;
         carry_ff <= carry_in;
      end
   end

   // The digit itself is payload.
   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign act_out   = act_ff;
   assign carry_out = carry_ff;
   assign digit_out = digit_ff;

endmodule

/* rtl/unsigned_radix_digit_emitter.sv */
// Channel | Direction | Handshake            | Beat payload
// req     | in        | req_valid, req_ready | req_data: value, radix, uppercase
// rsp     | out       | rsp_valid, rsp_ready | rsp_data: char_code, last_digit
//
// From its accept, an item's value bits enter the digit-cell array one per cycle
// and ripple one cell per cycle; then the array shifts out one cell per cycle, leading
// zero cells without a beat and the others only while rsp_ready is high. A new request
// can be accepted in the cycle after the last beat.
// Synchronous reset clears the sequencer and the activity chain; digits need no reset.
// rsp_ready low holds the current digit; req_ready is high only while idle.
module unsigned_radix_digit_emitter
   import urde_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   localparam int CNT_BITS = $clog2(VALUE_WIDTH + 1);
   localparam logic [CNT_BITS-1:0] DIGITS   = CNT_BITS'(VALUE_WIDTH);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(1);

   state_type                state_ff, state_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0]   val_ff, val_in;
   logic [RADIX_BITS-1:0]    radix_ff, radix_in;
   logic                     upper_ff, upper_in;
   logic                     started_ff, started_in;
   logic [RADIX_BITS-1:0]    radix_clamped;
   logic                     feed_act;
   logic                     shown;
   cell_ctl_type             ctl;
   logic [VALUE_WIDTH:0]     act;
   logic [VALUE_WIDTH:0]     carry;
   logic [DIGIT_BITS-1:0]    dig [VALUE_WIDTH+1];

   // Clamp the requested radix into two to sixteen.
   always_comb begin
      priority if (req_data.radix < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_data.radix > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end else begin
         radix_clamped = req_data.radix;
      end
   end

   // Bits enter the lowest cell most significant first.
   assign feed_act = (state_ff == ST_CONVERT) && (cnt_ff < DIGITS);
   assign act[0]   = feed_act;
   assign carry[0] = val_ff[VALUE_WIDTH-1];
   assign dig[0]   = '0;

   // One cell per possible digit; cell zero is the least significant.
   for (genvar i = 0; i < VALUE_WIDTH; i++) begin : g_cell
      urde_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .radix      (radix_ff),
         .act_prev   (act[i]),
         .carry_prev (carry[i]),
         .digit_prev (dig[i]),
         .act_out    (act[i+1]),
         .carry_out  (carry[i+1]),
         .digit_out  (dig[i+1])
      );
   end

   // A digit is shown once a nonzero digit was seen, or for the final cell.
   assign shown = started_ff || (dig[VALUE_WIDTH] != '0) || (cnt_ff == CNT_LAST);

   assign rsp_data.char_code  = char_of(dig[VALUE_WIDTH], upper_ff);
   assign rsp_data.last_digit = cnt_ff == CNT_LAST;

   // Sequencer: next state and outputs.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      val_in     = val_ff;
      radix_in   = radix_ff;
      upper_in   = upper_ff;
      started_in = started_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      ctl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               val_in     = req_data.value[VALUE_WIDTH-1:0];
               radix_in   = radix_clamped;
               upper_in   = req_data.uppercase;
               cnt_in     = '0;
               started_in = 1'b0;
               ctl.clear  = 1'b1;
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (feed_act) begin
               val_in = val_ff << 1;
               cnt_in = cnt_ff + CNT_LAST;
            end
            // The top cell has just finished its last doubling.
            if (act[VALUE_WIDTH] && !act[VALUE_WIDTH-1]) begin
               cnt_in   = DIGITS;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = shown;
            if (!shown || rsp_ready) begin
               ctl.shift  = 1'b1;
               cnt_in     = cnt_ff - CNT_LAST;
               started_in = started_ff | shown;
               if (shown && (cnt_ff == CNT_LAST)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         started_ff <= started_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      radix_ff <= radix_in;
      upper_ff <= upper_in;
   end

`ifndef ASSERT_OFF
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response sides active together");

   a_top_carry: assert property (@(posedge clock) disable iff (reset)
      !carry[VALUE_WIDTH])
      else $error("carry out of the top digit cell");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ((cnt_ff != '0) && (cnt_ff <= DIGITS)))
      else $error("digit counter out of range while emitting");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_digit) |=> req_ready)
      else $error("not idle after the last digit");

   a_act_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!act[VALUE_WIDTH] && !act[1]))
      else $error("digit cells still doubling while emitting");
`endif

endmodule
